/* rtl/ptod_pkg.sv */
// shared constants, types and sequencer states of the pooled t-test object detector
`timescale 1ns / 1ps
`default_nettype none
package ptod_pkg;

	// field widths
	localparam int DIST_W      = 14;
	localparam int CRIT_W      = 16;
	localparam int DIFF_W      = 19;
	localparam logic [CRIT_W-1:0] CRIT_RESET = 16'd6952;

	// set length limit and accumulator widths derived from it
	localparam int MAX_SAMPLES = 16;
	localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
	localparam int LOG_MAX     = $clog2(MAX_SAMPLES);
	localparam int SUM_W       = DIST_W + LOG_MAX;
	localparam int SQ_W        = 2 * DIST_W + 1;
	localparam int Q_W         = SQ_W + LOG_MAX;

	// evaluation widths
	localparam int NQ_W        = CNT_W + Q_W;
	localparam int SQS_W       = 2 * SUM_W;
	localparam int LHS_W       = SQS_W + CNT_W;
	localparam int FRAC2_W     = 24;
	localparam int PART_W      = 32;
	localparam int C2_W        = 2 * CRIT_W;
	localparam int VARP_W      = 2 * PART_W;
	localparam int PROD_W      = C2_W + PART_W;
	localparam int CMP_W       = C2_W + VARP_W;
	localparam int MAG_W       = (SUM_W > DIFF_W + 1) ? SUM_W : DIFF_W + 1;
	localparam int DIFF_POS_LIM = 2 ** (DIFF_W - 1) - 1;
	localparam int DIFF_NEG_LIM = 2 ** (DIFF_W - 1);

	// queue between front and back
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	// one finished set handed to the evaluator
	typedef struct packed {
		logic [CNT_W-1:0] n;
		logic [SUM_W-1:0] s1;
		logic [SUM_W-1:0] s2;
		logic [Q_W-1:0]   q;
	} job_t;

	// evaluator sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ,
		ST_SQ2,
		ST_VAR,
		ST_PLO,
		ST_PHI,
		ST_CMP
	} state_t;

endpackage
`default_nettype wire

/* rtl/ptod_if.sv */
// stream interfaces for sample words, result words and the configuration write
`timescale 1ns / 1ps
`default_nettype none
interface ptod_in_if;
	logic                         valid;
	logic                         ready;
	logic [ptod_pkg::DIST_W-1:0]  current_distance;
	logic [ptod_pkg::DIST_W-1:0]  reference_distance;
	logic                         last_sample;

	modport source (output valid, current_distance, reference_distance, last_sample,
		input ready);
	modport sink (input valid, current_distance, reference_distance, last_sample,
		output ready);
endinterface

interface ptod_out_if;
	logic                               valid;
	logic                               ready;
	logic                               object_found;
	logic signed [ptod_pkg::DIFF_W-1:0] sum_difference;

	modport source (output valid, object_found, sum_difference, input ready);
	modport sink (input valid, object_found, sum_difference, output ready);
endinterface

interface ptod_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [ptod_pkg::CRIT_W-1:0]  critical_value_q12;

	modport source (output valid, critical_value_q12, input ready);
	modport sink (input valid, critical_value_q12, output ready);
endinterface
`default_nettype wire

/* rtl/ptod_front.sv */
// front end: takes sample words, accumulates count, sums and sum of squares
`timescale 1ns / 1ps
`default_nettype none
module ptod_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	ptod_in_if.sink             samples,
	input  wire logic           q_full,
	output logic                q_push,
	output ptod_pkg::job_t      q_data
);
	import ptod_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] s1_q;
	logic [SUM_W-1:0] s2_q;
	logic [Q_W-1:0]   sq_q;

	logic             take;
	logic             accept;
	logic [SQ_W-1:0]  pair_sq;
	job_t             nxt;

	// word taken whenever the queue has room for a finished set
	assign samples.ready = !q_full;
	assign accept        = samples.valid && samples.ready;

	// pairs past the set limit are dropped
	assign take    = cnt_q < CNT_W'(MAX_SAMPLES);
	assign pair_sq = SQ_W'(SQ_W'(samples.current_distance) * SQ_W'(samples.current_distance))
		+ SQ_W'(SQ_W'(samples.reference_distance) * SQ_W'(samples.reference_distance));

	always_comb begin
		nxt.n  = cnt_q;
		nxt.s1 = s1_q;
		nxt.s2 = s2_q;
		nxt.q  = sq_q;
		if (take) begin
			nxt.n  = cnt_q + CNT_W'(1);
			nxt.s1 = s1_q + SUM_W'(samples.current_distance);
			nxt.s2 = s2_q + SUM_W'(samples.reference_distance);
			nxt.q  = sq_q + Q_W'(pair_sq);
		end
	end

	// hand the finished set to the queue
	assign q_push = accept && samples.last_sample;
	assign q_data = nxt;

	// accumulators, cleared at the end of each set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			s1_q  <= '0;
			s2_q  <= '0;
			sq_q  <= '0;
		end else if (accept) begin
			if (samples.last_sample) begin
				cnt_q <= '0;
				s1_q  <= '0;
				s2_q  <= '0;
				sq_q  <= '0;
			end else begin
				cnt_q <= nxt.n;
				s1_q  <= nxt.s1;
				s2_q  <= nxt.s2;
				sq_q  <= nxt.q;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/ptod_queue.sv */
// short queue of finished sets between front and back
`timescale 1ns / 1ps
`default_nettype none
module ptod_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire ptod_pkg::job_t push_data,
	output logic                full,
	input  wire logic           pop,
	output logic                not_empty,
	output ptod_pkg::job_t      pop_data
);
	import ptod_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full      = cnt_q == QCNT_W'(QDEPTH);
	assign not_empty = cnt_q != '0;
	assign pop_data  = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/ptod_back.sv */
// back end: evaluates the pooled t test for one set over a short step sequence
`timescale 1ns / 1ps
`default_nettype none
module ptod_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	ptod_cfg_if.sink            cfg,
	input  wire logic           q_valid,
	input  wire ptod_pkg::job_t q_data,
	output logic                q_pop,
	ptod_out_if.source          results
);
	import ptod_pkg::*;

	state_t             state_q;
	state_t             state_nxt;
	logic [CRIT_W-1:0]  crit_q;
	job_t               job_q;
	logic               neg_q;
	logic [SUM_W-1:0]   mag_q;
	logic [SQS_W-1:0]   sq1_q;
	logic [SQS_W-1:0]   sq2_q;
	logic [NQ_W-1:0]    nq_q;
	logic [C2_W-1:0]    c2_q;
	logic [SQS_W-1:0]   mag2_q;
	logic [NQ_W-1:0]    var_q;
	logic [LHS_W-1:0]   lhs_q;
	logic [PROD_W-1:0]  plo_q;
	logic [PROD_W-1:0]  phi_q;
	logic               res_valid_q;
	logic               res_found_q;
	logic [DIFF_W-1:0]  res_diff_q;

	logic               slot_free;
	logic               load_res;
	logic [VARP_W-1:0]  var_pad;
	logic [CMP_W-1:0]   lhs_sh;
	logic [CMP_W-1:0]   rhs;
	logic               found;
	logic [MAG_W-1:0]   mag_w;
	logic [MAG_W-1:0]   mag_lim;
	logic [MAG_W-1:0]   mag_c;
	logic [DIFF_W-1:0]  diff;

	// critical value register, always writable
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crit_q <= CRIT_RESET;
		end else if (cfg.valid) begin
			crit_q <= cfg.critical_value_q12;
		end
	end

	assign slot_free = !res_valid_q || results.ready;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (q_valid) state_nxt = ST_SQ;
			ST_SQ:   state_nxt = ST_SQ2;
			ST_SQ2:  state_nxt = ST_VAR;
			ST_VAR:  state_nxt = ST_PLO;
			ST_PLO:  state_nxt = ST_PHI;
			ST_PHI:  state_nxt = ST_CMP;
			ST_CMP:  if (slot_free) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// step outputs
	always_comb begin
		q_pop    = 1'b0;
		load_res = 1'b0;
		unique case (state_q)
			ST_IDLE: q_pop = q_valid;
			ST_CMP:  load_res = slot_free;
			default: begin
				q_pop    = 1'b0;
				load_res = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// final compare: D^2 (N-1) 2^24 against C^2 (N Q - S1^2 - S2^2)
	assign var_pad = VARP_W'(var_q);
	assign lhs_sh  = CMP_W'(lhs_q) << FRAC2_W;
	assign rhs     = (CMP_W'(phi_q) << PART_W) + CMP_W'(plo_q);
	assign found   = (job_q.n >= CNT_W'(2)) && neg_q && (lhs_sh > rhs);

	// signed difference, clamped to the output range
	assign mag_w   = MAG_W'(mag_q);
	assign mag_lim = neg_q ? MAG_W'(DIFF_NEG_LIM) : MAG_W'(DIFF_POS_LIM);
	assign mag_c   = (mag_w > mag_lim) ? mag_lim : mag_w;
	assign diff    = neg_q ? DIFF_W'(-mag_c) : DIFF_W'(mag_c);

	// datapath, one multiply per product per step
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) job_q <= q_data;
			end
			ST_SQ: begin
				neg_q <= job_q.s1 < job_q.s2;
				mag_q <= (job_q.s1 < job_q.s2) ? job_q.s2 - job_q.s1 : job_q.s1 - job_q.s2;
				sq1_q <= SQS_W'(job_q.s1) * SQS_W'(job_q.s1);
				nq_q  <= NQ_W'(job_q.n) * NQ_W'(job_q.q);
				c2_q  <= C2_W'(crit_q) * C2_W'(crit_q);
			end
			ST_SQ2: begin
				sq2_q  <= SQS_W'(job_q.s2) * SQS_W'(job_q.s2);
				mag2_q <= SQS_W'(mag_q) * SQS_W'(mag_q);
			end
			ST_VAR: begin
				var_q <= nq_q - NQ_W'(sq1_q) - NQ_W'(sq2_q);
				lhs_q <= LHS_W'(mag2_q) * LHS_W'(job_q.n - CNT_W'(1));
			end
			ST_PLO: begin
				plo_q <= PROD_W'(c2_q) * PROD_W'(var_pad[PART_W-1:0]);
			end
			ST_PHI: begin
				phi_q <= PROD_W'(c2_q) * PROD_W'(var_pad[VARP_W-1:PART_W]);
			end
			ST_CMP: begin
				if (load_res) begin
					res_found_q <= found;
					res_diff_q  <= diff;
				end
			end
			default: begin
				job_q <= job_q;
			end
		endcase
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign results.valid          = res_valid_q;
	assign results.object_found   = res_found_q;
	assign results.sum_difference = $signed(res_diff_q);

endmodule
`default_nettype wire

/* rtl/pooled_t_test_object_detect.sv */
// top level of the pooled two-sample t-test object detector
//
// Sample pairs are taken one word per clock while the queue has room and summed
// on the fly (count, both sums, combined sum of squares); a word marked last
// closes the set and sends it through a two-entry queue to the evaluator, which
// pops it and takes six steps through its shared sequencer before the result
// word is registered on the output. The accumulator keeps taking words while
// the evaluator works, so long sets stream at one pair per cycle; a run of
// short sets is paced by the evaluator, which takes a new set only once it is
// through with the last one. Pairs beyond sixteen in a set are dropped, the
// last word still ends the set. The critical value register may be written at
// any time but is only meant to change while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module pooled_t_test_object_detect (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ptod_in_if.sink    samples,
	ptod_out_if.source results,
	ptod_cfg_if.sink   cfg
);
	import ptod_pkg::*;

	logic push;
	logic full;
	logic pop;
	logic not_empty;
	job_t push_data;
	job_t pop_data;

	// accumulation of sample words
	ptod_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.q_full  (full),
		.q_push  (push),
		.q_data  (push_data)
	);

	// finished sets waiting for evaluation
	ptod_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_data  (pop_data)
	);

	// test evaluation and result word
	ptod_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_valid (not_empty),
		.q_data  (pop_data),
		.q_pop   (pop),
		.results (results)
	);

endmodule
`default_nettype wire

/* rtl/ptod_checker.sv */
// port-level checks of the object detector and their attachment to the top level
`timescale 1ns / 1ps
`default_nettype none
module ptod_port_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        in_last,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic                        out_found,
	input wire logic [ptod_pkg::DIFF_W-1:0] out_diff
);
	import ptod_pkg::*;

	localparam int OUTST_MAX = QDEPTH + 2;
	localparam int OUTST_W   = $clog2(OUTST_MAX + 2);

	logic               set_in;
	logic               word_out;
	logic [OUTST_W-1:0] outst_q;

	assign set_in   = in_valid && in_ready && in_last;
	assign word_out = out_valid && out_ready;

	// sets closed but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outst_q <= '0;
		end else if (set_in && !word_out) begin
			outst_q <= outst_q + OUTST_W'(1);
		end else if (word_out && !set_in) begin
			outst_q <= outst_q - OUTST_W'(1);
		end
	end

	// a result word only for a set that was closed
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> outst_q != '0)
		else $error("result word without a pending set");

	// sets in flight fit the queue, the evaluator and the output register
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		outst_q <= OUTST_W'(OUTST_MAX))
		else $error("more sets in flight than the block can hold");

	// found means the current sum lies below the reference sum
	a_found_neg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_found |-> out_diff[DIFF_W-1])
		else $error("object found with non-negative difference");

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_found) && $stable(out_diff))
		else $error("result word changed while stalled");

endmodule

bind pooled_t_test_object_detect ptod_port_checker u_ptod_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.in_last   (samples.last_sample),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_found (results.object_found),
	.out_diff  (results.sum_difference)
);
`default_nettype wire
